// ===== design/serial_frame_deframer_macros.svh =====
// Assertion macros used by the serial frame deframer port checker.
// No dependencies; include once per file that asserts.
`ifndef SERIAL_FRAME_DEFRAMER_MACROS_SVH
`define SERIAL_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define SFD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfd assertion failed");

// Next-cycle implication, masked while reset is asserted.
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define SFD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("sfd assertion failed");

`endif

// ===== design/sfd_pkg.sv =====
// Shared types and constants of the serial frame deframer.
// No dependencies.
package sfd_pkg;

    localparam int unsigned PAYLOAD_BYTES = 9;
    localparam int unsigned CNT_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int unsigned IDX_W = $clog2(PAYLOAD_BYTES);

    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'h55;
    localparam logic [7:0] TRL_FIRST  = 8'hDF;
    localparam logic [7:0] TRL_SECOND = 8'hFD;

    typedef struct packed {
        logic        overrun;
        logic [15:0] word_four;
        logic [15:0] word_three;
        logic [15:0] word_two;
        logic [15:0] word_one;
        logic [7:0]  ctrl_byte;
    } t_result;

endpackage

// ===== design/serial_frame_deframer.sv =====
// Serial frame deframer, top level.
// Depends on sfd_pkg, sfd_core and sfd_out_stage.
//
// Usage:
//   The slave channel carries one received byte per transfer. The block
//   hunts for the header 0xAA 0x55, collects up to nine payload bytes and
//   closes the frame on the trailer 0xDF 0xFD. A 0xDF not followed by 0xFD
//   is kept as payload along with the byte after it.
//   For each closed frame the master channel carries one transfer: payload
//   byte 0 and four big-endian 16-bit words from bytes 1 to 8 in tdata,
//   and in tuser a flag set when payload bytes past the ninth were dropped.
//   Bytes not written in a short frame read as zero.
// Frame end: the closing 0xFD is captured in the input register, decoded there
//   and, once the result slot is free, loaded into the result register, where
//   it shows on the master side.
// Throughput: one byte per cycle unless a frame end waits for a busy result slot,
//   set by the state update between the input register and the result register.
// Reset: returns to header hunting with an empty, zeroed payload store and
//   no pending result.
// Stall: a stalled result holds in the result register while bytes that
//   close no frame keep flowing; a second frame end waits in the input
//   register, and only then is o_s_tready dropped.
module serial_frame_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [7:0] ctrl_byte, [23:8] word_one, [39:24] word_two,
                                     // [55:40] word_three, [71:56] word_four
    output logic        o_m_tuser    // [0] overrun
);
    import sfd_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       res_gen;
    logic       out_free;
    logic       fire;
    t_result    core_res;
    t_result    out_res;

    // advance the held byte unless it closes a frame and the result slot is busy
    assign fire       = r_in_vld && (!res_gen || out_free);
    assign o_s_tready = !r_in_vld || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    // payload register: capture on every transfer
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    sfd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_byte    (r_in_byte),
        .o_res_gen (res_gen),
        .o_result  (core_res)
    );

    sfd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && res_gen),
        .i_result (core_res),
        .i_tready (i_m_tready),
        .o_free   (out_free),
        .o_tvalid (o_m_tvalid),
        .o_result (out_res)
    );

    assign o_m_tdata = {out_res.word_four, out_res.word_three, out_res.word_two,
                        out_res.word_one, out_res.ctrl_byte};
    assign o_m_tuser = out_res.overrun;

endmodule

// ===== design/sfd_core.sv =====
// Frame state machine and nine-byte payload store of the deframer.
// Depends on sfd_pkg.
module sfd_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  logic [7:0]       i_byte,
    output logic             o_res_gen,
    output sfd_pkg::t_result o_result
);
    import sfd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEAD,
        PH_RECV,
        PH_TAIL
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [7:0]       r_store [PAYLOAD_BYTES];
    logic [7:0]       n_store [PAYLOAD_BYTES];
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;

    assign o_res_gen = (r_phase == PH_TAIL) && (i_byte == TRL_SECOND);

    assign o_result.ctrl_byte  = r_store[0];
    assign o_result.word_one   = {r_store[1], r_store[2]};
    assign o_result.word_two   = {r_store[3], r_store[4]};
    assign o_result.word_three = {r_store[5], r_store[6]};
    assign o_result.word_four  = {r_store[7], r_store[8]};
    assign o_result.overrun    = r_ovf;

    always_comb begin
        n_phase = r_phase;
        n_store = r_store;
        n_count = r_count;
        n_ovf   = r_ovf;
        if (i_fire) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_byte == HDR_FIRST) n_phase = PH_HEAD;
                end
                PH_HEAD: begin
                    if (i_byte == HDR_SECOND) n_phase = PH_RECV;
                end
                PH_RECV: begin
                    if (i_byte == TRL_FIRST) begin
                        n_phase = PH_TAIL;
                    end else if (n_count < CNT_W'(PAYLOAD_BYTES)) begin
                        n_store[n_count[IDX_W-1:0]] = i_byte;
                        n_count = n_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
                PH_TAIL: begin
                    if (i_byte == TRL_SECOND) begin
                        // frame end: clear store for the next frame
                        n_store = '{default: '0};
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_phase = PH_IDLE;
                    end else begin
                        // store the held-back trailer byte, then this byte
                        if (n_count < CNT_W'(PAYLOAD_BYTES)) begin
                            n_store[n_count[IDX_W-1:0]] = TRL_FIRST;
                            n_count = n_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        if (n_count < CNT_W'(PAYLOAD_BYTES)) begin
                            n_store[n_count[IDX_W-1:0]] = i_byte;
                            n_count = n_count + CNT_W'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_phase = PH_RECV;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_store <= '{default: '0};
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_store <= n_store;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

endmodule

// ===== design/sfd_out_stage.sv =====
// Result register of the deframer: holds one frame result until transferred.
// Depends on sfd_pkg.
module sfd_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  sfd_pkg::t_result i_result,
    input  logic             i_tready,
    output logic             o_free,
    output logic             o_tvalid,
    output sfd_pkg::t_result o_result
);
    import sfd_pkg::*;

    logic    r_vld;
    t_result r_res;

    // slot is free when empty or being emptied this cycle
    assign o_free   = !r_vld || i_tready;
    assign o_tvalid = r_vld;
    assign o_result = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (i_tready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

endmodule

// ===== design/sfd_checker.sv =====
// Port-level checks of the serial frame deframer, bound to the top level.
// Depends on serial_frame_deframer_macros.svh and serial_frame_deframer.
`include "serial_frame_deframer_macros.svh"

module sfd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic        o_m_tuser
);

    // a stalled result stays offered
    `SFD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)

    // a stalled result keeps its payload
    `SFD_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready,
                     $stable(o_m_tdata) && $stable(o_m_tuser))

    // input backpressure only when a result is stuck at the output
    `SFD_ASSERT_NOW(a_bp_cause, i_clk, i_rst_n, !o_s_tready, o_m_tvalid && !i_m_tready)

    // reset leaves no result pending
    `SFD_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind serial_frame_deframer sfd_checker u_sfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== tb/sfd_frame_checker.sv =====
// Scoreboard for the serial frame deframer: tracks its header/trailer hunt per byte transfer.
// It compares each result transfer with the oldest frame still due.
// Depends on sfd_pkg for the header and trailer codes, the payload size and the result layout.
module sfd_frame_checker
    import sfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] rx_byte
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [71:0] i_m_tdata,   // [7:0] ctrl_byte, [23:8] word_one, [39:24] word_two,
                                     // [55:40] word_three, [71:56] word_four
    input  logic        i_m_tuser,   // [0] overrun
    output int          o_mismatches,
    output int          o_outstanding
);

    typedef enum logic [1:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        COLLECT,
        HELD_TRAILER
    } t_hunt;

    t_hunt       hunt_state;
    logic [7:0]  frame_store [PAYLOAD_BYTES];
    int unsigned fill_level;
    logic        dropped_any;
    t_result     frames_due [$];
    int          mismatch_count;

    initial begin
        hunt_state = HUNT_FIRST;
        for (int i = 0; i < PAYLOAD_BYTES; i++) begin
            frame_store[i] = 8'h00;
        end
        fill_level     = 0;
        dropped_any    = 1'b0;
        mismatch_count = 0;
    end

    task automatic keep_byte(input logic [7:0] b);
        if (fill_level < PAYLOAD_BYTES) begin
            frame_store[fill_level] = b;
            fill_level++;
        end else begin
            dropped_any = 1'b1;
        end
    endtask

    // Advance the hunt by one received byte; queue a frame when the trailer closes.
    task automatic advance_deframer(input logic [7:0] b);
        t_result frame;
        if (hunt_state == COLLECT && b == TRL_FIRST) begin
            hunt_state = HELD_TRAILER;
            return;
        end
        if (hunt_state == HELD_TRAILER) begin
            if (b == TRL_SECOND) begin
                frame.ctrl_byte  = frame_store[0];
                frame.word_one   = {frame_store[1], frame_store[2]};
                frame.word_two   = {frame_store[3], frame_store[4]};
                frame.word_three = {frame_store[5], frame_store[6]};
                frame.word_four  = {frame_store[7], frame_store[8]};
                frame.overrun    = dropped_any;
                frames_due.push_back(frame);
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    frame_store[i] = 8'h00;
                end
                fill_level  = 0;
                dropped_any = 1'b0;
                hunt_state  = HUNT_FIRST;
                return;
            end
            // Lone 0xDF: keep it, then keep the current byte too.
            keep_byte(TRL_FIRST);
            hunt_state = COLLECT;
        end
        case (hunt_state)
            HUNT_FIRST: begin
                if (b == HDR_FIRST) hunt_state = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                if (b == HDR_SECOND) hunt_state = COLLECT;
            end
            COLLECT: begin
                keep_byte(b);
            end
            default: begin
            end
        endcase
    endtask

    task automatic field_check(input string field, input int exp, input int act);
        if (exp != act) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("frame mismatch on %s: expected %h, got %h", field, exp, act);
            end
        end
    endtask

    task automatic check_frame(input t_result got);
        t_result due;
        if (frames_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("unexpected frame result %h", got);
            end
            return;
        end
        due = frames_due.pop_front();
        field_check("ctrl_byte",  due.ctrl_byte,  got.ctrl_byte);
        field_check("word_one",   due.word_one,   got.word_one);
        field_check("word_two",   due.word_two,   got.word_two);
        field_check("word_three", due.word_three, got.word_three);
        field_check("word_four",  due.word_four,  got.word_four);
        field_check("overrun",    due.overrun,    got.overrun);
    endtask

    // Check the result first: a byte taken on this edge cannot close a frame seen on it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) check_frame(t_result'({i_m_tuser, i_m_tdata}));
            if (i_s_tvalid && i_s_tready) advance_deframer(i_s_tdata);
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= frames_due.size();
    end

endmodule

// ===== tb/tb_serial_frame_deframer.sv =====
// Top-level testbench of the serial frame deframer: it generates byte transfers and drives the result handshake.
// It delivers the verdict.
// Depends on sfd_pkg, serial_frame_deframer and sfd_frame_checker.
module tb_serial_frame_deframer;
    import sfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int          ITEMS_PER_RUN = 410;   // frame bytes per random phase
    localparam int          HOLD_CYCLES   = 80;    // long result-side hold-off
    localparam int          TAIL_CYCLES   = 16;    // settle time after the last result

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        m_tuser;

    int          mismatches;
    int          outstanding;
    int unsigned cycle_count;

    // Idle odds in percent, set by the stimulus process per phase.
    int          send_idle_pct;
    int          recv_idle_pct;
    // Hold-off requests: stimulus bumps the request, the receiver acknowledges.
    int          stall_req;
    int          frame_items;

    serial_frame_deframer u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    sfd_frame_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: end the run if it overstays the cycle budget.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("tb_serial_frame_deframer: done, errors");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    initial begin
        int stall_ack;
        int hold_left;
        stall_ack = 0;
        hold_left = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (stall_ack != stall_req) begin
                stall_ack = stall_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte, with random idle cycles ahead of it; return once s_tready reads high.
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_counted(input logic [7:0] b);
        send_byte(b);
        frame_items++;
    endtask

    task automatic send_seq(input logic [7:0] seq [$]);
        foreach (seq[i]) send_counted(seq[i]);
    endtask

    // Payload content is weighted toward the framing codes and the byte extremes.
    function automatic logic [7:0] pick_payload_byte();
        int unsigned r;
        r = $urandom_range(11);
        case (r)
            0, 1:    return TRL_FIRST;
            2:       return TRL_SECOND;
            3:       return HDR_FIRST;
            4:       return HDR_SECOND;
            5:       return 8'h00;
            6:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Send a header, n payload bytes and, when asked, the closing trailer.
    // Optionally put junk between the two header bytes.
    task automatic send_frame(input int n, input bit with_trailer, input bit header_junk);
        logic [7:0] junk;
        send_counted(HDR_FIRST);
        if (header_junk) begin
            repeat ($urandom_range(1, 3)) begin
                junk = 8'($urandom_range(255));
                if (junk == HDR_SECOND) junk = 8'h00;
                send_counted(junk);
            end
        end
        send_counted(HDR_SECOND);
        repeat (n) send_counted(pick_payload_byte());
        if (with_trailer) begin
            send_counted(TRL_FIRST);
            send_counted(TRL_SECOND);
        end
    endtask

    // Mostly well-formed frames; some overlong, some cut short, with noise between them.
    task automatic random_traffic(input int items);
        int start;
        int unsigned r;
        int len;
        start = frame_items;
        while (frame_items - start < items) begin
            r   = $urandom_range(99);
            len = ($urandom_range(99) < 85) ? $urandom_range(0, PAYLOAD_BYTES)
                                            : $urandom_range(PAYLOAD_BYTES + 1, 13);
            if (r < 8) begin
                // Noise between frames, left out of the count; the block ignores it only while hunting for a header.
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)));
            end else if (r < 14) begin
                send_frame(len, 1'b0, 1'b0);
            end else begin
                send_frame(len, 1'b1, $urandom_range(9) == 0);
            end
        end
    endtask

    // Pause the sender until every predicted frame has come out.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    initial begin
        rst_n         <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= 8'h00;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_req     = 0;
        frame_items   = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int run = 0; run < 3; run++) begin
            case (run)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 88;
                end
                1: begin
                    send_idle_pct = 88;
                    recv_idle_pct = 36;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (run == 0) begin
                // Ignored idle byte, then an empty frame.
                send_seq('{8'h00, HDR_FIRST, HDR_SECOND, TRL_FIRST, TRL_SECOND});
                // Junk between the header bytes, then a full frame of alternating extremes.
                send_seq('{HDR_FIRST, 8'h3C, HDR_SECOND, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                           8'h00, 8'hFF, 8'h00, 8'hFF, TRL_FIRST, TRL_SECOND});
                // Lone 0xDF kept as payload in a short frame.
                send_seq('{HDR_FIRST, HDR_SECOND, TRL_FIRST, 8'h01, TRL_FIRST, TRL_SECOND});
                // Overlong frame: extra bytes, held 0xDF included, get dropped.
                send_seq('{HDR_FIRST, HDR_SECOND, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A, 8'h5A,
                           8'h5A, 8'h5A, 8'h5A, TRL_FIRST, 8'h7E, TRL_FIRST, TRL_SECOND});
            end

            if (run == 2) begin
                // Hold the result side off while empty frames keep coming, so the input stalls.
                stall_req <= stall_req + 1;
                repeat (8) send_frame(0, 1'b1, 1'b0);
            end

            random_traffic(ITEMS_PER_RUN);
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_serial_frame_deframer: done, clean");
        end else begin
            $display("tb_serial_frame_deframer: done, errors");
        end
        $finish;
    end

endmodule

// ===== serial_frame_deframer.f =====
+incdir+design
design/sfd_pkg.sv
design/sfd_core.sv
design/sfd_out_stage.sv
design/serial_frame_deframer.sv
design/sfd_checker.sv
tb/sfd_frame_checker.sv
tb/tb_serial_frame_deframer.sv
